// File: src/srct_pkg.sv
// Shared constants, codes and types of the session reference-count table.
package srct_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W        = 32;
   localparam int COUNT_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_W     = ID_W + COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic OP_OPEN  = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                new_entry;
      logic                entry_removed;
      logic [COUNT_W-1:0]  session_count;
   } srct_result_type;

   typedef struct packed {
      logic            start;
      logic            opcode;
      logic [ID_W-1:0] user_id;
      logic            take;
   } srct_cmd_type;

   typedef struct packed {
      logic            busy;
      logic            res_valid;
      srct_result_type result;
   } srct_stat_type;

endpackage

// File: src/srct_engine.sv
// Table memory with the search, update and compaction sequencer.
module srct_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  srct_pkg::srct_cmd_type  cmd,
   output srct_pkg::srct_stat_type stat
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_ACT    = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   localparam int IDX_W   = srct_pkg::IDX_W;
   localparam int USED_W  = srct_pkg::USED_W;
   localparam int ID_W    = srct_pkg::ID_W;
   localparam int COUNT_W = srct_pkg::COUNT_W;
   localparam int ENTRY_W = srct_pkg::ENTRY_W;
   localparam logic [USED_W-1:0] USED_MAX = USED_W'(srct_pkg::MAX_ENTRIES);

   logic [ENTRY_W-1:0] mem [srct_pkg::MAX_ENTRIES];

   logic [2:0]               state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [USED_W-1:0]        used_ff, used_in;
   logic                     op_ff, op_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic                     found_ff, found_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   srct_pkg::srct_result_type res_ff, res_in;
   logic [ENTRY_W-1:0]       rd_data_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ID_W-1:0]    rd_id;
   logic [COUNT_W-1:0] rd_cnt;
   logic [USED_W-1:0]  idx1;
   logic [COUNT_W-1:0] cnt_inc, cnt_dec;

   assign rd_id   = rd_data_ff[ENTRY_W-1:COUNT_W];
   assign rd_cnt  = rd_data_ff[COUNT_W-1:0];
   assign idx1    = USED_W'(idx_ff) + USED_W'(1);
   assign cnt_inc = (cnt_ff == srct_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + COUNT_W'(1);
   assign cnt_dec = (cnt_ff == '0) ? cnt_ff : cnt_ff - COUNT_W'(1);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      used_in  = used_ff;
      op_in    = op_ff;
      id_in    = id_ff;
      found_in = found_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = {id_ff, cnt_ff};
      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (cmd.start) begin
               op_in  = cmd.opcode;
               id_in  = cmd.user_id;
               idx_in = '0;
               if (used_ff == '0) begin
                  found_in = 1'b0;
                  state_in = S_ACT;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            rd_addr = IDX_W'(idx1);
            if (rd_id == id_ff) begin
               found_in = 1'b1;
               cnt_in   = rd_cnt;
               state_in = S_ACT;
            end else if (idx1 >= used_ff) begin
               found_in = 1'b0;
               state_in = S_ACT;
            end else begin
               idx_in = IDX_W'(idx1);
            end
         end
         S_ACT: begin
            rd_addr  = IDX_W'(idx1);
            res_in   = '0;
            state_in = S_RESULT;
            if (op_ff == srct_pkg::OP_OPEN) begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_data = {id_ff, cnt_inc};
                  res_in.session_count = cnt_inc;
               end else if (used_ff == USED_MAX) begin
                  res_in.status = srct_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(used_ff);
                  wr_data = {id_ff, COUNT_W'(1)};
                  used_in = used_ff + USED_W'(1);
                  res_in.new_entry     = 1'b1;
                  res_in.session_count = COUNT_W'(1);
               end
            end else begin
               if (!found_ff) begin
                  res_in.status = srct_pkg::ST_NOT_FOUND;
               end else if (cnt_dec != '0) begin
                  wr_en   = 1'b1;
                  wr_data = {id_ff, cnt_dec};
                  res_in.session_count = cnt_dec;
               end else begin
                  used_in = used_ff - USED_W'(1);
                  res_in.entry_removed = 1'b1;
                  if (idx1 < used_ff) begin
                     state_in = S_SHIFT;
                  end
               end
            end
         end
         S_SHIFT: begin
            rd_addr = IDX_W'(idx1 + USED_W'(1));
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = IDX_W'(idx1);
            if (!(idx1 < used_ff)) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (cmd.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      op_ff    <= op_in;
      id_ff    <= id_in;
      found_ff <= found_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.busy      = (state_ff != S_IDLE);
   assign stat.res_valid = (state_ff == S_RESULT);
   assign stat.result    = res_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_MAX)
      else $error("entry count exceeds table size");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> idx1 <= used_ff)
      else $error("compaction beyond valid entries");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == S_IDLE)
      else $error("transaction started while busy");

   a_used_change: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && used_ff != $past(used_ff) |-> $past(state_ff) == S_ACT)
      else $error("entry count changed outside update");

   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      stat.res_valid && res_ff.entry_removed |->
         res_ff.session_count == '0 && res_ff.status == srct_pkg::ST_OK)
      else $error("removal result carries a count");

endmodule

// File: src/session_reference_count_table_unit.sv
// Session reference-count table: request intake, engine and result register.
//
// Usage: a request transaction carries req_opcode (open or close) and
// req_user_id. It is taken at a rising edge where req_valid is high and
// req_stall is low. Each request yields exactly one response transaction
// on the rsp_ channel: rsp_status, rsp_new_entry, rsp_entry_removed and
// rsp_session_count.
// Sequencing: one request at a time. The table sits in one
// single-port-read memory; the search reads one entry per cycle and stops
// at the matching entry or after the last entry in use. The request then
// passes the update and result states before the response register loads.
// A close that removes an entry also copies each later entry down one
// position. The next request is taken once the response has loaded.
// req_stall stays high while a request is in work.
// Reset clears the entry count, the sequencer state and the response valid flag; the table is empty.
// While rsp_stall is high the response register holds its transaction;
// the engine holds a finished result until that register frees up.
module session_reference_count_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [srct_pkg::ID_W-1:0]     req_user_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [srct_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_new_entry,
   output logic                          rsp_entry_removed,
   output logic [srct_pkg::COUNT_W-1:0]  rsp_session_count
);

   srct_pkg::srct_cmd_type    cmd;
   srct_pkg::srct_stat_type   stat;
   logic                      rsp_valid_ff, rsp_valid_in;
   srct_pkg::srct_result_type rsp_ff;
   logic                      load;

   assign req_stall   = stat.busy;
   assign load        = stat.res_valid && (!rsp_valid_ff || !rsp_stall);

   assign cmd.start   = req_valid && !stat.busy;
   assign cmd.opcode  = req_opcode;
   assign cmd.user_id = req_user_id;
   assign cmd.take    = load;

   srct_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= stat.result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_new_entry     = rsp_ff.new_entry;
   assign rsp_entry_removed = rsp_ff.entry_removed;
   assign rsp_session_count = rsp_ff.session_count;

endmodule

// File: tb/session_reference_count_table_unit_tb.sv
// Self-checking testbench for the session reference-count table unit under random traffic.
module session_reference_count_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ID_W          = srct_pkg::ID_W;
   localparam int COUNT_W       = srct_pkg::COUNT_W;
   localparam int STATUS_W      = srct_pkg::STATUS_W;
   localparam int MAX_ENTRIES   = srct_pkg::MAX_ENTRIES;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int LONG_HOLD     = 400;
   localparam int POOL_SIZE     = MAX_ENTRIES + 8;
   localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 16;

   typedef struct packed {
      logic            opcode;
      logic [ID_W-1:0] user_id;
   } session_request_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic                req_opcode  = srct_pkg::OP_OPEN;
   logic [ID_W-1:0]     req_user_id = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_new_entry;
   logic                rsp_entry_removed;
   logic [COUNT_W-1:0]  rsp_session_count;
   logic                req_taken   = 1'b0;

   session_request_type       pending_requests[$];
   srct_pkg::srct_result_type expected_results[$];

   logic [ID_W-1:0]    session_ids[MAX_ENTRIES];
   logic [COUNT_W-1:0] session_counts[MAX_ENTRIES];
   int                 session_users = 0;

   logic [ID_W-1:0] id_pool[POOL_SIZE];
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int holds_requested = 0;
   int holds_started   = 0;
   int hold_left       = 0;
   int error_count     = 0;
   int cycle_count     = 0;

   session_reference_count_table_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_user_id       (req_user_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_new_entry     (rsp_new_entry),
      .rsp_entry_removed (rsp_entry_removed),
      .rsp_session_count (rsp_session_count)
   );

   always #4 clock = ~clock;

   function automatic srct_pkg::srct_result_type track_session_event(
         input logic opcode, input logic [ID_W-1:0] user_id);
      srct_pkg::srct_result_type result;
      int                        slot;
      logic [COUNT_W-1:0]        count;
      result = '0;
      slot   = session_users;
      for (int k = session_users - 1; k >= 0; k--) begin
         if (session_ids[k] == user_id) slot = k;
      end
      if (opcode == srct_pkg::OP_OPEN) begin
         if (slot < session_users) begin
            count = session_counts[slot];
            if (count != srct_pkg::COUNT_MAX) count = count + COUNT_W'(1);
            session_counts[slot] = count;
            result.session_count = count;
         end else if (session_users < MAX_ENTRIES) begin
            session_ids[session_users]    = user_id;
            session_counts[session_users] = COUNT_W'(1);
            session_users++;
            result.new_entry     = 1'b1;
            result.session_count = COUNT_W'(1);
         end else begin
            result.status = srct_pkg::ST_FULL;
         end
      end else if (slot < session_users) begin
         count = session_counts[slot];
         if (count != '0) count = count - COUNT_W'(1);
         if (count == '0) begin
            for (int k = slot; k + 1 < session_users; k++) begin
               session_ids[k]    = session_ids[k + 1];
               session_counts[k] = session_counts[k + 1];
            end
            session_users--;
            result.entry_removed = 1'b1;
         end else begin
            session_counts[slot] = count;
            result.session_count = count;
         end
      end else begin
         result.status = srct_pkg::ST_NOT_FOUND;
      end
      return result;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   task automatic queue_request(input logic opcode, input logic [ID_W-1:0] user_id);
      session_request_type item;
      item.opcode  = opcode;
      item.user_id = user_id;
      pending_requests.push_back(item);
   endtask

   task automatic wait_until_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   // fill the table past capacity, then alternate close-heavy and open-heavy stretches
   task automatic queue_session_traffic();
      logic            opcode;
      logic [ID_W-1:0] user_id;
      int              open_pct;
      for (int k = 0; k < POOL_SIZE; k++) begin
         id_pool[k] = $urandom();
         queue_request(srct_pkg::OP_OPEN, id_pool[k]);
      end
      for (int seg = 0; seg < 4; seg++) begin
         open_pct = (seg % 2 == 0) ? 30 : 75;
         for (int n = 0; n < 80; n++) begin
            opcode  = ($urandom_range(99) < open_pct) ? srct_pkg::OP_OPEN
                                                      : srct_pkg::OP_CLOSE;
            user_id = ($urandom_range(99) < 88) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                                : $urandom();
            queue_request(opcode, user_id);
         end
      end
   endtask

   always @(negedge clock) begin : request_drive
      session_request_type next_request;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_request = pending_requests.pop_front();
            req_valid   <= 1'b1;
            req_opcode  <= next_request.opcode;
            req_user_id <= next_request.user_id;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : response_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_started != holds_requested && rsp_valid) begin
         rsp_stall     <= 1'b1;
         hold_left     <= LONG_HOLD;
         holds_started <= holds_started + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : response_check
      srct_pkg::srct_result_type oldest;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_results.push_back(track_session_event(req_opcode, req_user_id));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h %0b %0b %0h",
                        $time, rsp_status, rsp_new_entry, rsp_entry_removed,
                        rsp_session_count);
               error_count++;
            end else begin
               oldest = expected_results.pop_front();
               compare_field("status", 32'(oldest.status), 32'(rsp_status));
               compare_field("new_entry", 32'(oldest.new_entry), 32'(rsp_new_entry));
               compare_field("entry_removed", 32'(oldest.entry_removed),
                             32'(rsp_entry_removed));
               compare_field("session_count", 32'(oldest.session_count),
                             32'(rsp_session_count));
            end
         end
      end
   end

   always @(posedge clock) begin : run_limit
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("session_reference_count_table_unit test failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      send_idle_pct = 8;
      recv_idle_pct = 62;
      holds_requested++;
      queue_request(srct_pkg::OP_CLOSE, 32'h0000_0000);
      queue_request(srct_pkg::OP_OPEN, 32'h0000_0000);
      queue_request(srct_pkg::OP_OPEN, 32'h0000_0000);
      queue_request(srct_pkg::OP_OPEN, 32'hFFFF_FFFF);
      queue_request(srct_pkg::OP_OPEN, 32'hAAAA_AAAA);
      queue_request(srct_pkg::OP_OPEN, 32'h5555_5555);
      queue_request(srct_pkg::OP_CLOSE, 32'h1234_5678);
      queue_request(srct_pkg::OP_CLOSE, 32'h0000_0000);
      queue_request(srct_pkg::OP_CLOSE, 32'h0000_0000);
      queue_request(srct_pkg::OP_CLOSE, 32'h0000_0000);
      queue_request(srct_pkg::OP_OPEN, 32'hFFFF_FFFF);
      queue_request(srct_pkg::OP_CLOSE, 32'h5555_5555);
      queue_request(srct_pkg::OP_OPEN, 32'h5555_5555);
      queue_request(srct_pkg::OP_CLOSE, 32'hAAAA_AAAA);
      queue_request(srct_pkg::OP_CLOSE, 32'hFFFF_FFFF);
      queue_request(srct_pkg::OP_CLOSE, 32'hFFFF_FFFF);
      queue_request(srct_pkg::OP_CLOSE, 32'h5555_5555);
      queue_request(srct_pkg::OP_OPEN, 32'h8000_0000);
      queue_request(srct_pkg::OP_OPEN, 32'h0000_0001);
      queue_request(srct_pkg::OP_CLOSE, 32'h8000_0000);
      queue_session_traffic();
      wait_until_drained();

      send_idle_pct = 62;
      recv_idle_pct = 8;
      holds_requested++;
      queue_session_traffic();
      wait_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_requested++;
      queue_session_traffic();
      wait_until_drained();

      // empty the table from the front
      for (int k = 0; k < session_users; k++) begin
         repeat (session_counts[k]) queue_request(srct_pkg::OP_CLOSE, session_ids[k]);
      end
      wait_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("session_reference_count_table_unit test passed");
      end else begin
         $display("session_reference_count_table_unit test failed");
      end
      $finish;
   end

endmodule
